>>> sv/nearest_neighbor_scaled_blit_top_macros.svh
// assertion macros for the nearest neighbor scaled blit block
// expects clk and rst_n in the scope where a macro is used
`ifndef NEAREST_NEIGHBOR_SCALED_BLIT_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALED_BLIT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define NNSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NNSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NNSB_ASSERT(lbl, prop, msg)
`define NNSB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/nnsb_pkg.sv
// shared types, constants and helpers for the nearest neighbor scaled blit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package nnsb_pkg;

    localparam int SRC_PIXELS  = 65536;
    localparam int DISP_WIDTH  = 1024;
    localparam int DISP_HEIGHT = 768;

    localparam int ADDR_W     = $clog2(SRC_PIXELS);
    localparam int COLOR_W    = 24;
    localparam int LIN_W      = 26;
    localparam int NUM_W      = 26;
    localparam int Q_W        = 13;
    localparam int DIV_STAGES = Q_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]         CHAN_MAX  = 8'd255;
    localparam logic [COLOR_W-1:0] WHITE_KEY = {CHAN_MAX, CHAN_MAX, CHAN_MAX};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_X,
        REG_DST_Y,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_DRAW_MODE
    } reg_idx_t;

    typedef struct packed {
        logic [11:0]        src_width;
        logic signed [12:0] src_height;
        logic signed [12:0] dst_x;
        logic signed [12:0] dst_y;
        logic [12:0]        dst_width;
        logic [12:0]        dst_height;
        logic [1:0]         draw_mode;
    } cfg_t;

    typedef struct packed {
        logic               is_draw;
        logic               ok;
        logic [10:0]        row;
        logic [10:0]        col;
        logic [COLOR_W-1:0] color;
        logic [11:0]        dx;
        logic [11:0]        dy;
        logic signed [13:0] scr_x;
        logic signed [13:0] scr_y;
    } fe_item_t;

    typedef struct packed {
        logic               is_draw;
        logic               ok;
        logic signed [13:0] scr_x;
        logic signed [13:0] scr_y;
        logic [COLOR_W-1:0] color;
        logic [LIN_W-1:0]   lin_addr;
    } bk_meta_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [12:0] abs_height(input logic signed [12:0] h);
        logic signed [12:0] neg;
        neg = -h;
        return h[12] ? 13'(neg) : 13'(h);
    endfunction

endpackage
`default_nettype wire

>>> sv/nnsb_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module nnsb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> sv/nnsb_fifo.sv
// short item queue between the front and back parts
// depends on nnsb_pkg
`timescale 1ns / 1ps
`default_nettype none
module nnsb_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire nnsb_pkg::fe_item_t push_item,
    input  wire logic              pop,
    output nnsb_pkg::fe_item_t     head,
    output nnsb_pkg::q_stat_t      stat
);
    import nnsb_pkg::*;

    fe_item_t           mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wptr_reg, rptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign head       = mem_reg[rptr_reg];
    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

>>> sv/nnsb_front.sv
// front part: configuration registers, input accept and item classification
// depends on nnsb_pkg
`timescale 1ns / 1ps
`default_nettype none
module nnsb_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [12:0]             cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    cmd,
    input  wire logic [10:0]             src_row,
    input  wire logic [10:0]             src_col,
    input  wire logic [23:0]             pixel_color,
    input  wire logic [11:0]             dx,
    input  wire logic [11:0]             dy,
    input  wire nnsb_pkg::q_stat_t       q_stat,
    output logic                         q_push,
    output nnsb_pkg::fe_item_t           q_item,
    output nnsb_pkg::cfg_t               cfg
);
    import nnsb_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic [12:0] abs_h;
    logic        geom_ok, in_rect, on_screen, clip;
    logic signed [13:0] scr_x, scr_y;

    assign cfg       = cfg_reg;
    assign cfg_ready = 1'b1;
    assign in_ready  = !q_stat.full;
    assign q_push    = in_valid && !q_stat.full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SRC_WIDTH:  cfg_next.src_width  = cfg_data[11:0];
                REG_SRC_HEIGHT: cfg_next.src_height = cfg_data;
                REG_DST_X:      cfg_next.dst_x      = cfg_data;
                REG_DST_Y:      cfg_next.dst_y      = cfg_data;
                REG_DST_WIDTH:  cfg_next.dst_width  = cfg_data;
                REG_DST_HEIGHT: cfg_next.dst_height = cfg_data;
                REG_DRAW_MODE:  cfg_next.draw_mode  = cfg_data[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= 12'd1;
            cfg_reg.src_height <= 13'sd1;
            cfg_reg.dst_x      <= '0;
            cfg_reg.dst_y      <= '0;
            cfg_reg.dst_width  <= 13'd1;
            cfg_reg.dst_height <= 13'd1;
            cfg_reg.draw_mode  <= 2'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify the item while it is accepted
    always_comb
    begin
        abs_h     = abs_height(cfg_reg.src_height);
        clip      = cfg_reg.draw_mode[0];
        scr_x     = $signed({cfg_reg.dst_x[12], cfg_reg.dst_x}) + $signed({2'b00, dx});
        scr_y     = $signed({cfg_reg.dst_y[12], cfg_reg.dst_y}) + $signed({2'b00, dy});
        geom_ok   = (cfg_reg.src_width != '0) && (abs_h != '0)
                    && (cfg_reg.dst_width != '0) && (cfg_reg.dst_height != '0);
        in_rect   = ({1'b0, dx} < cfg_reg.dst_width) && ({1'b0, dy} < cfg_reg.dst_height);
        on_screen = !scr_x[13] && !scr_y[13]
                    && ($unsigned(scr_x) < 14'(DISP_WIDTH))
                    && ($unsigned(scr_y) < 14'(DISP_HEIGHT));

        q_item.is_draw = (cmd == CMD_DRAW);
        q_item.row     = src_row;
        q_item.col     = src_col;
        q_item.color   = pixel_color;
        q_item.dx      = dx;
        q_item.dy      = dy;
        q_item.scr_x   = scr_x;
        q_item.scr_y   = scr_y;
        if (cmd == CMD_DRAW)
        begin
            q_item.ok = geom_ok && in_rect && (!clip || on_screen);
        end
        else
        begin
            q_item.ok = ({1'b0, src_col} < cfg_reg.src_width);
        end
    end
endmodule
`default_nettype wire

>>> sv/nnsb_back.sv
// back part: scale multiply, pipelined divide, clamp, store access, result register
// depends on nnsb_pkg and nnsb_ram
`timescale 1ns / 1ps
`default_nettype none
module nnsb_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nnsb_pkg::cfg_t        cfg,
    input  wire nnsb_pkg::q_stat_t     q_stat,
    input  wire nnsb_pkg::fe_item_t    q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       write_enable,
    output logic signed [13:0]         pix_x,
    output logic signed [13:0]         pix_y,
    output logic [23:0]                out_color
);
    import nnsb_pkg::*;

    logic        en;
    logic        icon;
    logic [12:0] abs_h;

    // stage s0: item taken from the queue
    logic     s0_valid_reg;
    fe_item_t s0_item_reg;

    // divider pipeline, index 0 holds the scaled numerators
    logic             dv_valid_reg [0:DIV_STAGES];
    bk_meta_t         dv_meta_reg  [0:DIV_STAGES];
    logic [NUM_W-1:0] rem_x_reg    [0:DIV_STAGES];
    logic [NUM_W-1:0] rem_y_reg    [0:DIV_STAGES];
    logic [Q_W-1:0]   q_x_reg      [0:DIV_STAGES];
    logic [Q_W-1:0]   q_y_reg      [0:DIV_STAGES];

    logic [NUM_W-1:0] num_x, num_y;
    logic [LIN_W-1:0] load_lin;

    // clamp stage
    logic           c_valid_reg;
    bk_meta_t       c_meta_reg;
    logic [Q_W-1:0] c_sx_reg, c_ridx_reg;
    logic [Q_W-1:0] sx_cl, sy_cl, ridx;

    // address stage
    logic             a_valid_reg;
    bk_meta_t         a_meta_reg;
    logic [LIN_W-1:0] a_lin_reg;
    logic [LIN_W-1:0] a_lin;
    logic             a_in_range;

    // store access stage
    logic               m_valid_reg;
    bk_meta_t           m_meta_reg;
    logic               m_hit_reg;
    logic [COLOR_W-1:0] rd_data;
    logic               wr_en;
    logic               we_now;

    // result register
    logic               out_valid_reg;
    logic               we_reg;
    logic signed [13:0] sx_reg, sy_reg;
    logic [COLOR_W-1:0] color_reg;

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_stat.empty;
    assign icon  = cfg.draw_mode[1];
    assign abs_h = abs_height(cfg.src_height);

    // scale multiply with optional half-span rounding term
    always_comb
    begin
        num_x = NUM_W'(s0_item_reg.dx) * NUM_W'(cfg.src_width)
                + (icon ? NUM_W'(cfg.dst_width >> 1) : '0);
        num_y = NUM_W'(s0_item_reg.dy) * NUM_W'(abs_h)
                + (icon ? NUM_W'(cfg.dst_height >> 1) : '0);
        load_lin = LIN_W'(s0_item_reg.row) * LIN_W'(cfg.src_width)
                   + LIN_W'(s0_item_reg.col);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg          <= q_head;
            rem_x_reg[0]         <= num_x;
            rem_y_reg[0]         <= num_y;
            q_x_reg[0]           <= '0;
            q_y_reg[0]           <= '0;
            dv_meta_reg[0].is_draw  <= s0_item_reg.is_draw;
            dv_meta_reg[0].ok       <= s0_item_reg.ok;
            dv_meta_reg[0].scr_x    <= s0_item_reg.scr_x;
            dv_meta_reg[0].scr_y    <= s0_item_reg.scr_y;
            dv_meta_reg[0].color    <= s0_item_reg.color;
            dv_meta_reg[0].lin_addr <= load_lin;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] dv_x, dv_y;
        assign dv_x = NUM_W'(cfg.dst_width) << B;
        assign dv_y = NUM_W'(cfg.dst_height) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_meta_reg[k+1] <= dv_meta_reg[k];
                if (rem_x_reg[k] >= dv_x)
                begin
                    rem_x_reg[k+1] <= rem_x_reg[k] - dv_x;
                    q_x_reg[k+1]   <= q_x_reg[k] | (Q_W'(1) << B);
                end
                else
                begin
                    rem_x_reg[k+1] <= rem_x_reg[k];
                    q_x_reg[k+1]   <= q_x_reg[k];
                end
                if (rem_y_reg[k] >= dv_y)
                begin
                    rem_y_reg[k+1] <= rem_y_reg[k] - dv_y;
                    q_y_reg[k+1]   <= q_y_reg[k] | (Q_W'(1) << B);
                end
                else
                begin
                    rem_y_reg[k+1] <= rem_y_reg[k];
                    q_y_reg[k+1]   <= q_y_reg[k];
                end
            end
        end
    end

    // clamp to the image, flip rows for bottom-up storage
    always_comb
    begin
        sx_cl = (q_x_reg[DIV_STAGES] >= Q_W'(cfg.src_width))
                ? Q_W'(cfg.src_width) - 1'b1 : q_x_reg[DIV_STAGES];
        sy_cl = (q_y_reg[DIV_STAGES] >= abs_h) ? abs_h - 1'b1 : q_y_reg[DIV_STAGES];
        if (!cfg.src_height[12] && (cfg.src_height != '0))
        begin
            ridx = abs_h - 1'b1 - sy_cl;
        end
        else
        begin
            ridx = sy_cl;
        end
    end

    always_comb
    begin
        if (c_meta_reg.is_draw)
        begin
            a_lin = LIN_W'(c_ridx_reg) * LIN_W'(cfg.src_width) + LIN_W'(c_sx_reg);
        end
        else
        begin
            a_lin = c_meta_reg.lin_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_meta_reg <= dv_meta_reg[DIV_STAGES];
            c_sx_reg   <= sx_cl;
            c_ridx_reg <= ridx;
            a_meta_reg <= c_meta_reg;
            a_lin_reg  <= a_lin;
            m_meta_reg <= a_meta_reg;
            m_hit_reg  <= a_in_range;
            we_reg     <= we_now;
            sx_reg     <= m_meta_reg.is_draw ? m_meta_reg.scr_x : '0;
            sy_reg     <= m_meta_reg.is_draw ? m_meta_reg.scr_y : '0;
            color_reg  <= we_now ? rd_data : '0;
        end
    end

    // loads write and draws read at the same stage, so program order holds
    assign a_in_range = (a_lin_reg < LIN_W'(SRC_PIXELS));
    assign wr_en      = en && a_valid_reg && !a_meta_reg.is_draw
                        && a_meta_reg.ok && a_in_range;

    nnsb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (SRC_PIXELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (a_lin_reg[ADDR_W-1:0]),
        .wr_data (a_meta_reg.color),
        .rd_en   (en),
        .rd_addr (a_lin_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign we_now = m_meta_reg.is_draw && m_meta_reg.ok && m_hit_reg
                    && !(icon && (rd_data == WHITE_KEY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
            c_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= !q_stat.empty;
            dv_valid_reg[0] <= s0_valid_reg;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
            c_valid_reg   <= dv_valid_reg[DIV_STAGES];
            a_valid_reg   <= c_valid_reg;
            m_valid_reg   <= a_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign pix_x        = sx_reg;
    assign pix_y        = sy_reg;
    assign out_color    = color_reg;
endmodule
`default_nettype wire

>>> sv/nearest_neighbor_scaled_blit_top.sv
// top level of the nearest neighbor scaled blit: front, item queue, back
// depends on nnsb_pkg, nnsb_front, nnsb_fifo, nnsb_back and the macros header
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in       | in_valid / in_ready    | cmd, src_row, src_col, pixel_color, dx, dy
//  out      | out_valid / out_ready  | write_enable, pix_x, pix_y, out_color
//
// one item per clock sustained while the output is not stalled
// an item passes the 13-stage divider, one quotient bit per stage, plus
// the scale and address multiplies and the registered store read
// an output stall freezes the back pipeline; the 4-entry queue takes items until full
// no clearing pass after reset: the store is undefined until loaded
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_scaled_blit_top_macros.svh"
module nearest_neighbor_scaled_blit_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [12:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [10:0]        src_row,
    input  wire logic [10:0]        src_col,
    input  wire logic [23:0]        pixel_color,
    input  wire logic [11:0]        dx,
    input  wire logic [11:0]        dy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    write_enable,
    output logic signed [13:0]      pix_x,
    output logic signed [13:0]      pix_y,
    output logic [23:0]             out_color
);
    import nnsb_pkg::*;

    cfg_t     cfg;
    q_stat_t  q_stat;
    fe_item_t q_item, q_head;
    logic     q_push, q_pop;

    nnsb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .src_row     (src_row),
        .src_col     (src_col),
        .pixel_color (pixel_color),
        .dx          (dx),
        .dy          (dy),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_item      (q_item),
        .cfg         (cfg)
    );

    nnsb_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    nnsb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .out_color    (out_color)
    );

    `NNSB_ASSERT(a_key_dropped, (out_valid && write_enable && cfg.draw_mode[1]) |-> (out_color != WHITE_KEY), "keyed white pixel written")
    `NNSB_ASSERT(a_clip_held, (out_valid && write_enable && cfg.draw_mode[0]) |-> (!pix_x[13] && !pix_y[13] && (pix_x < 14'(DISP_WIDTH)) && (pix_y < 14'(DISP_HEIGHT))), "clipped write left the screen")
    `NNSB_ASSERT(a_quiet_color, (out_valid && !write_enable) |-> (out_color == '0), "suppressed result carries a color")
    `NNSB_ASSERT_NEXT(a_queue_drains, q_stat.full && q_pop, in_ready, "queue stayed full after a pop")
endmodule
`default_nettype wire

>>> dv/nearest_neighbor_scaled_blit_top_tb.sv
// testbench for the nearest neighbor scaled blit: random and directed loads and draws
// a scoreboard class predicts each screen write; depends on nnsb_pkg and the top level
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_scaled_blit_top_tb;
    import nnsb_pkg::*;

    typedef struct {
        logic               we;
        logic signed [13:0] sx;
        logic signed [13:0] sy;
        logic [23:0]        color;
    } blit_result_t;

    class blit_scoreboard;
        logic [11:0]        src_w;
        logic signed [12:0] src_h;
        logic signed [12:0] org_x;
        logic signed [12:0] org_y;
        logic [12:0]        rect_w;
        logic [12:0]        rect_h;
        logic [1:0]         mode;
        logic [23:0]        pixels[int];
        blit_result_t       pending_writes[$];
        int                 errors;
        int                 n_loads;
        int                 n_draws;
        int                 n_written;

        function void reset_regs();
            src_w = 1; src_h = 1; org_x = 0; org_y = 0;
            rect_w = 1; rect_h = 1; mode = 1;
        endfunction

        function void set_reg(reg_idx_t idx, logic [12:0] v);
            case (idx)
                REG_SRC_WIDTH:  src_w = v[11:0];
                REG_SRC_HEIGHT: src_h = v;
                REG_DST_X:      org_x = v;
                REG_DST_Y:      org_y = v;
                REG_DST_WIDTH:  rect_w = v;
                REG_DST_HEIGHT: rect_h = v;
                REG_DRAW_MODE:  mode = v[1:0];
                default: ;
            endcase
        endfunction

        function int scale_pos(int d, int m, int n);
            int q;
            q = (d * m + (mode[1] ? n / 2 : 0)) / n;
            return q >= m ? m - 1 : q;
        endfunction

        // linear source address a draw reads, with its row and column, or -1 when it reads nothing
        function int fetch_addr(int ddx, int ddy, output int ridx, output int scol);
            int hh, scx, scy, srow;
            hh = src_h < 0 ? -int'(src_h) : int'(src_h);
            scx = int'(org_x) + ddx;
            scy = int'(org_y) + ddy;
            ridx = 0; scol = 0;
            if (src_w == 0 || hh == 0 || rect_w == 0 || rect_h == 0) return -1;
            if (ddx >= rect_w || ddy >= rect_h) return -1;
            if (mode[0] && (scx < 0 || scx >= DISP_WIDTH || scy < 0 || scy >= DISP_HEIGHT))
                return -1;
            srow = scale_pos(ddy, hh, rect_h);
            scol = scale_pos(ddx, src_w, rect_w);
            ridx = src_h > 0 ? hh - 1 - srow : srow;
            if (ridx * src_w + scol >= SRC_PIXELS) return -1;
            return ridx * src_w + scol;
        endfunction

        function void note_input(logic c, int row, int col, logic [23:0] pc, int ddx, int ddy);
            blit_result_t r;
            int a, ri, sc;
            r.we = 0; r.sx = 0; r.sy = 0; r.color = 0;
            if (c == CMD_LOAD) begin
                n_loads++;
                a = row * src_w + col;
                if (col < src_w && a < SRC_PIXELS) pixels[a] = pc;
            end else begin
                n_draws++;
                r.sx = 14'(int'(org_x) + ddx);
                r.sy = 14'(int'(org_y) + ddy);
                a = fetch_addr(ddx, ddy, ri, sc);
                if (a >= 0) begin
                    r.color = pixels[a];
                    r.we = 1;
                    if (mode[1] && r.color == WHITE_KEY) begin
                        r.we = 0;
                        r.color = 0;
                    end
                end
            end
            pending_writes.push_back(r);
        endfunction

        function void check_result(logic we, logic signed [13:0] sx, logic signed [13:0] sy,
                                   logic [23:0] color);
            blit_result_t e;
            if (pending_writes.size() == 0) begin
                $error("result with nothing expected: we=%0d x=%0d y=%0d", we, sx, sy);
                errors++;
                return;
            end
            e = pending_writes.pop_front();
            if (e.we) n_written++;
            if (we !== e.we) begin
                $error("write_enable expected %0d actual %0d", e.we, we); errors++;
            end
            if (sx !== e.sx) begin
                $error("pix_x expected %0d actual %0d", e.sx, sx); errors++;
            end
            if (sy !== e.sy) begin
                $error("pix_y expected %0d actual %0d", e.sy, sy); errors++;
            end
            if (color !== e.color) begin
                $error("out_color expected %h actual %h", e.color, color); errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [12:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [10:0]        src_row;
    logic [10:0]        src_col;
    logic [23:0]        pixel_color;
    logic [11:0]        dx;
    logic [11:0]        dy;
    logic               out_valid;
    logic               out_ready;
    logic               write_enable;
    logic signed [13:0] pix_x;
    logic signed [13:0] pix_y;
    logic [23:0]        out_color;

    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int white_pct;
    blit_scoreboard sb;

    nearest_neighbor_scaled_blit_top u_top (.*);

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(write_enable, pix_x, pix_y, out_color);
    end

    task automatic send_item(logic c, int row, int col, logic [23:0] pc, int ddx, int ddy);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        src_row     <= 11'(row);
        src_col     <= 11'(col);
        pixel_color <= pc;
        dx          <= 12'(ddx);
        dy          <= 12'(ddy);
        do @(posedge clk); while (!in_ready);
        sb.note_input(c, row, col, pc, ddx, ddy);
    endtask

    function automatic logic [23:0] pick_color();
        return ($urandom_range(99) < white_pct) ? WHITE_KEY : 24'($urandom);
    endfunction

    // a draw whose source pixel was never loaded gets that pixel loaded first
    task automatic draw(int ddx, int ddy);
        int a, ri, sc;
        a = sb.fetch_addr(ddx, ddy, ri, sc);
        if (a >= 0 && !sb.pixels.exists(a))
            send_item(CMD_LOAD, ri, sc, pick_color(), $urandom_range(4095),
                      $urandom_range(4095));
        send_item(CMD_DRAW, $urandom_range(2047), $urandom_range(2047), 24'($urandom),
                  ddx, ddy);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_regs(int w, int h, int x, int y, int dw, int dh, int m);
        int vals[7];
        vals = '{w, h, x, y, dw, dh, m};
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= 13'(vals[i]);
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(reg_idx_t'(i), 13'(vals[i]));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        int hh;
        for (int i = 0; i < n; i++)
        begin
            hh = sb.src_h < 0 ? -int'(sb.src_h) : int'(sb.src_h);
            case ($urandom_range(19))
                0, 1:
                    send_item(CMD_LOAD, $urandom_range(2047), $urandom_range(2047),
                              24'($urandom), $urandom_range(4095), $urandom_range(4095));
                2:
                    send_item(CMD_LOAD, $urandom_range(hh > 0 ? hh - 1 : 0),
                              $urandom_range(sb.src_w - 1), pick_color(), 0, 0);
                3, 4:
                    draw($urandom_range(4095), $urandom_range(4095));
                default:
                    draw($urandom_range(sb.rect_w - 1), $urandom_range(sb.rect_h - 1));
            endcase
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("[nearest_neighbor_scaled_blit_top] ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_regs();
        idle_pct = 0; stall_pct = 0; hold_req = 0; white_pct = 10;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; cmd = CMD_LOAD; src_row = '0; src_col = '0;
        pixel_color = '0; dx = '0; dy = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at reset settings: ignored loads, a legal tall load, rectangle edges
        send_item(CMD_LOAD, 2047, 2047, WHITE_KEY, 4095, 4095);
        send_item(CMD_LOAD, 2047, 0, 24'hA5A5A5, 0, 0);
        send_item(CMD_LOAD, 0, 1, 24'h5A5A5A, 0, 0);
        send_item(CMD_LOAD, 0, 0, 24'h000000, 0, 0);
        draw(0, 0);
        draw(4095, 4095);
        draw(1, 0);
        draw(0, 1);
        send_item(CMD_LOAD, 0, 0, WHITE_KEY, 0, 0);
        draw(0, 0);
        drain();

        // icon mode with white key and clipping at the screen corner
        write_regs(2, -2, 1023, 767, 2, 2, 3);
        send_item(CMD_LOAD, 0, 0, WHITE_KEY, 0, 0);
        send_item(CMD_LOAD, 0, 1, 24'h123456, 0, 0);
        send_item(CMD_LOAD, 1, 0, 24'hFEDCBA, 0, 0);
        send_item(CMD_LOAD, 1, 1, WHITE_KEY, 0, 0);
        draw(0, 0); draw(1, 0); draw(0, 1); draw(1, 1);
        drain();

        write_regs(4, 3, 0, 0, 9, 7, 0);
        random_items(80);
        drain();

        idle_pct = 79;
        write_regs(5, -4, 1020, 764, 8, 8, 1);
        random_items(120);
        drain();

        idle_pct = 0; stall_pct = 79; white_pct = 30;
        write_regs(3, 6, -4096, 4095, 7, 10, 3);
        random_items(40);
        hold_req = hold_req + 1;
        random_items(80);
        drain();

        idle_pct = 27; stall_pct = 27; white_pct = 10;
        write_regs(2048, 2048, 4095, -4096, 4096, 4096, 2);
        random_items(120);
        drain();

        write_regs(7, 0, 10, 10, 5, 5, 1);
        random_items(40);
        drain();

        white_pct = 25;
        write_regs(1, -2048, -5, 10, 3, 4096, 3);
        random_items(120);
        drain();

        idle_pct = 0; stall_pct = 0;
        write_regs(6, 5, 100, 200, 13, 11, 2);
        random_items(100);
        stall_pct = 79;
        hold_req = hold_req + 1;
        random_items(100);
        drain();

        $display("covered %0d loads and %0d draws, %0d screen writes, over nine settings",
                 sb.n_loads, sb.n_draws, sb.n_written);
        $display("with clip and icon modes, both row orders, empty height and idle mixes");
        if (sb.errors == 0)
            $display("[nearest_neighbor_scaled_blit_top] OK");
        else
            $display("[nearest_neighbor_scaled_blit_top] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
